[rtl/core/sscol_pkg.sv]
// Shared types and constants of the swept-sphere contact time pipeline.
// No dependencies; every module of the block imports this package.
package sscol_pkg;

    // Result status codes on the output beat.
    typedef enum logic [2:0] {
        ST_MISS       = 3'd0,
        ST_SEPARATING = 3'd1,
        ST_OVERLAP    = 3'd2,
        ST_CONTACT    = 3'd3,
        ST_LATE       = 3'd4,
        ST_STILL      = 3'd5
    } status_t;

    localparam int STATUS_BITS = 3;

    // Lane count of the vector math.
    localparam int LANES = 3;

endpackage

[rtl/core/sscol_prep.sv]
// Front end: relative motion and the three quadratic coefficients a, b, c.
// Depends on sscol_pkg; two register stages.
module sscol_prep #(
    parameter int W = 32,
    parameter int T = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [7*W-2+T:0]      in_data,
    output logic                  out_valid,
    output logic signed [2*W+2:0] a_out,
    output logic signed [2*W+2:0] b_out,
    output logic signed [2*W+2:0] c_out,
    output logic [T-1:0]          f_out
);
    import sscol_pkg::*;

    localparam int AW = 2*W+3;
    localparam int PW = 2*W+2;

    logic signed [W:0]    d_w   [LANES];
    logic signed [W-1:0]  s_w   [LANES];
    logic signed [PW-1:0] dd_next [LANES];
    logic signed [PW-1:0] sd_next [LANES];
    logic signed [PW-1:0] ss_next [LANES];
    logic signed [PW-1:0] dd_reg  [LANES];
    logic signed [PW-1:0] sd_reg  [LANES];
    logic signed [PW-1:0] ss_reg  [LANES];
    logic [2*W-3:0]       rr_reg;
    logic [W-2:0]         r_w;
    logic [T-1:0]         f1_reg;
    logic                 v1_reg;
    logic signed [AW-1:0] a_next, b_next, c_next;

    // Stage one: per-lane motion and the products of each lane.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            s_w[i]     = $signed(in_data[i*W +: W]);
            d_w[i]     = (W+1)'($signed(in_data[(i+3)*W +: W])) - (W+1)'(s_w[i]);
            dd_next[i] = PW'(d_w[i]) * PW'(d_w[i]);
            sd_next[i] = PW'(s_w[i]) * PW'(d_w[i]);
            ss_next[i] = PW'(s_w[i]) * PW'(s_w[i]);
        end
        r_w = in_data[6*W +: W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dd_reg <= dd_next;
            sd_reg <= sd_next;
            ss_reg <= ss_next;
            rr_reg <= r_w * r_w;
            f1_reg <= in_data[7*W-1 +: T];
        end
    end

    // Stage two: sum the lanes into the coefficients.
    always_comb begin
        a_next = '0;
        b_next = '0;
        c_next = -AW'($signed({1'b0, rr_reg}));
        for (int i = 0; i < LANES; i++) begin
            a_next = a_next + AW'(dd_reg[i]);
            b_next = b_next + AW'(sd_reg[i]);
            c_next = c_next + AW'(ss_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_out <= a_next;
            b_out <= b_next;
            c_out <= c_next;
            f_out <= f1_reg;
        end
    end

endmodule

[rtl/core/sscol_disc.sv]
// Discriminant sign, quadratic evaluated at the start time, and status decision.
// Depends on sscol_pkg; five register stages.
module sscol_disc #(
    parameter int W = 32,
    parameter int T = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [2*W+2:0]       a_in,
    input  logic signed [2*W+2:0]       b_in,
    input  logic signed [2*W+2:0]       c_in,
    input  logic [T-1:0]                f_in,
    output logic                        out_valid,
    output logic signed [2*W+2:0]       a_out,
    output logic signed [2*W+2*T+6:0]   h0_out,
    output logic signed [2*W+2*T+6:0]   g0_out,
    output sscol_pkg::status_t          status_out,
    output logic [T-1:0]                f_out
);
    import sscol_pkg::*;

    localparam int AW  = 2*W+3;
    localparam int HB  = W+1;          // half width of a magnitude
    localparam int PW  = 2*HB;         // partial product width
    localparam int QW  = 4*HB;         // full square width
    localparam int UW  = AW+T+2;       // slope term width
    localparam int GW  = AW+2*T+4;     // polynomial value width

    // Stage three: magnitude split into halves, partial products, a*phi.
    logic [PW-1:0] amag, bmag, cmag;
    logic [PW-1:0] bll_reg, blh_reg, bhh_reg;
    logic [PW-1:0] all_reg, alh_reg, ahl_reg, ahh_reg;
    logic signed [UW-1:0] af_reg;
    logic signed [AW-1:0] a3_reg, b3_reg, c3_reg;
    logic [T-1:0] f3_reg;
    logic v3_reg, cneg3_reg, azero3_reg, b1pos3_reg, c1neg3_reg;
    logic signed [AW+1:0] b1_w, c1_w;

    always_comb begin
        amag = a_in[PW-1:0];
        bmag = b_in[AW-1] ? PW'(-b_in) : b_in[PW-1:0];
        cmag = c_in[AW-1] ? PW'(-c_in) : c_in[PW-1:0];
        b1_w = (AW+2)'(a_in) + (AW+2)'(b_in);
        c1_w = b1_w + (AW+2)'(b_in) + (AW+2)'(c_in);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bll_reg    <= PW'(bmag[HB-1:0]) * PW'(bmag[HB-1:0]);
            blh_reg    <= PW'(bmag[HB-1:0]) * PW'(bmag[PW-1:HB]);
            bhh_reg    <= PW'(bmag[PW-1:HB]) * PW'(bmag[PW-1:HB]);
            all_reg    <= PW'(amag[HB-1:0]) * PW'(cmag[HB-1:0]);
            alh_reg    <= PW'(amag[HB-1:0]) * PW'(cmag[PW-1:HB]);
            ahl_reg    <= PW'(amag[PW-1:HB]) * PW'(cmag[HB-1:0]);
            ahh_reg    <= PW'(amag[PW-1:HB]) * PW'(cmag[PW-1:HB]);
            af_reg     <= UW'(a_in) * UW'($signed({1'b0, f_in}));
            a3_reg     <= a_in;
            b3_reg     <= b_in;
            c3_reg     <= c_in;
            f3_reg     <= f_in;
            cneg3_reg  <= c_in[AW-1];
            azero3_reg <= (a_in == '0);
            b1pos3_reg <= !b1_w[AW+1] && (b1_w != '0);
            c1neg3_reg <= c1_w[AW+1];
        end
    end

    // Stage four: assemble b squared and a times |c|; slope at phi.
    logic [QW-1:0] bsq4_reg, acm4_reg;
    logic signed [GW-1:0] h4_reg;
    logic signed [UW-1:0] u4_reg;
    logic signed [AW-1:0] a4_reg, c4_reg;
    logic signed [GW-1:0] g04_reg, h04_reg;
    logic [T-1:0] f4_reg;
    logic v4_reg, cneg4_reg, azero4_reg, b1pos4_reg, c1neg4_reg;
    logic signed [UW-1:0] h_w, bp_w;

    always_comb begin
        bp_w = UW'(b3_reg) <<< T;
        h_w  = af_reg + bp_w;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bsq4_reg   <= {bhh_reg, bll_reg} + (QW'(blh_reg) << (HB+1));
            acm4_reg   <= {ahh_reg, all_reg} + (QW'(alh_reg) << HB) + (QW'(ahl_reg) << HB);
            h4_reg     <= GW'(h_w);
            u4_reg     <= h_w + bp_w;
            a4_reg     <= a3_reg;
            c4_reg     <= c3_reg;
            h04_reg    <= GW'(bp_w);
            g04_reg    <= GW'(c3_reg) <<< (2*T);
            f4_reg     <= f3_reg;
            cneg4_reg  <= cneg3_reg;
            azero4_reg <= azero3_reg;
            b1pos4_reg <= b1pos3_reg;
            c1neg4_reg <= c1neg3_reg;
        end
    end

    // Stage five: discriminant sign and the product for the value at phi.
    logic signed [GW-1:0] uf5_reg, h5_reg, h05_reg, g05_reg;
    logic signed [AW-1:0] a5_reg, c5_reg;
    logic [T-1:0] f5_reg;
    logic v5_reg, dneg5_reg, azero5_reg, b1pos5_reg, c1neg5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            uf5_reg    <= GW'(u4_reg) * GW'($signed({1'b0, f4_reg}));
            dneg5_reg  <= !cneg4_reg && (bsq4_reg < acm4_reg);
            h5_reg     <= h4_reg;
            h05_reg    <= h04_reg;
            g05_reg    <= g04_reg;
            a5_reg     <= a4_reg;
            c5_reg     <= c4_reg;
            f5_reg     <= f4_reg;
            azero5_reg <= azero4_reg;
            b1pos5_reg <= b1pos4_reg;
            c1neg5_reg <= c1neg4_reg;
        end
    end

    // Stage six: value of the quadratic at phi.
    logic signed [GW-1:0] cf6_reg, h6_reg, h06_reg, g06_reg;
    logic signed [AW-1:0] a6_reg;
    logic [T-1:0] f6_reg;
    logic v6_reg, dneg6_reg, azero6_reg, b1pos6_reg, c1neg6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cf6_reg    <= uf5_reg + (GW'(c5_reg) <<< (2*T));
            h6_reg     <= h5_reg;
            h06_reg    <= h05_reg;
            g06_reg    <= g05_reg;
            a6_reg     <= a5_reg;
            f6_reg     <= f5_reg;
            dneg6_reg  <= dneg5_reg;
            azero6_reg <= azero5_reg;
            b1pos6_reg <= b1pos5_reg;
            c1neg6_reg <= c1neg5_reg;
        end
    end

    // Stage seven: classify the pair.
    status_t status_next;
    logic hpos, cfpos, cfneg, cfzero;

    always_comb begin
        hpos   = !h6_reg[GW-1] && (h6_reg != '0);
        cfneg  = cf6_reg[GW-1];
        cfzero = (cf6_reg == '0);
        cfpos  = !cfneg && !cfzero;
        if (azero6_reg) begin
            status_next = ST_STILL;
        end else if (dneg6_reg) begin
            status_next = ST_MISS;
        end else if (hpos && cfpos) begin
            status_next = ST_SEPARATING;
        end else if (cfneg || (cfzero && hpos)) begin
            status_next = ST_OVERLAP;
        end else if (b1pos6_reg || c1neg6_reg) begin
            status_next = ST_CONTACT;
        end else begin
            status_next = ST_LATE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            status_out <= status_next;
            a_out      <= a6_reg;
            h0_out     <= h06_reg;
            g0_out     <= g06_reg;
            f_out      <= f6_reg;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            out_valid <= 1'b0;
        end else if (en) begin
            v3_reg    <= in_valid;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            out_valid <= v6_reg;
        end
    end

endmodule

[rtl/core/sscol_bisect.sv]
// One bit of the contact time search: tests k + 2^BIT with shifts and adds.
// Depends on sscol_pkg; one register stage.
module sscol_bisect #(
    parameter int W   = 32,
    parameter int T   = 16,
    parameter int BIT = 0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [2*W+2:0]     a_in,
    input  logic signed [2*W+2*T+6:0] h_in,
    input  logic signed [2*W+2*T+6:0] g_in,
    input  logic [T-1:0]              k_in,
    input  sscol_pkg::status_t        status_in,
    input  logic [T-1:0]              f_in,
    output logic                      out_valid,
    output logic signed [2*W+2:0]     a_out,
    output logic signed [2*W+2*T+6:0] h_out,
    output logic signed [2*W+2*T+6:0] g_out,
    output logic [T-1:0]              k_out,
    output sscol_pkg::status_t        status_out,
    output logic [T-1:0]              f_out
);
    import sscol_pkg::*;

    localparam int GW = 2*W+2*T+7;

    logic signed [GW-1:0] ax, hc, gc;
    logic take;

    // Slope and value at the candidate; keep it if the first root lies at or after it.
    always_comb begin
        ax   = GW'(a_in);
        hc   = h_in + (ax <<< BIT);
        gc   = g_in + (h_in <<< (BIT+1)) + (ax <<< (2*BIT));
        take = (hc[GW-1] || (hc == '0)) && !gc[GW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_out      <= a_in;
            h_out      <= take ? hc : h_in;
            g_out      <= take ? gc : g_in;
            k_out      <= take ? (k_in | T'(1) << BIT) : k_in;
            status_out <= status_in;
            f_out      <= f_in;
        end
    end

endmodule

[rtl/core/swept_sphere_collision_time_top.sv]
// Top level of the swept-sphere first contact time pipeline.
// Depends on sscol_pkg, sscol_prep, sscol_disc and sscol_bisect.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one sphere pair per
//   beat: start and end offsets, radius sum and elapsed frame time. The master
//   channel (m_tvalid, m_tready, m_tdata) returns one beat per pair with the
//   hit flag, the contact time and the status code.
//   Throughput is one pair per cycle while the output is not stalled. From an
//   accepted input beat to the output beat, two stages form the coefficients,
//   five find the discriminant sign, the value at the start time and the
//   status, one stage per time bit runs the binary search of the contact time,
//   and one output register holds the result.
//   Reset clears every valid bit; the data registers have no reset.
//   When the receiver stalls with a beat waiting, the whole pipeline holds in
//   place and s_tready drops, so no beat is lost or repeated.
module swept_sphere_collision_time_top #(
    parameter int COORD_WIDTH = 32,
    parameter int TIME_BITS   = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // Fields from bit 0: rel_start_x, rel_start_y, rel_start_z, rel_end_x,
    // rel_end_y, rel_end_z, radius_sum, frame_time, zero fill.
    input  logic [((7*COORD_WIDTH-1+TIME_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // Fields from bit 0: hit, collision_time, status, zero fill.
    output logic [((TIME_BITS+4+7)/8)*8-1:0] m_tdata
);
    import sscol_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int T  = TIME_BITS;
    localparam int AW = 2*W+3;
    localparam int GW = 2*W+2*T+7;
    localparam int IB = 7*W-1+T;
    localparam int OB = ((T+4+7)/8)*8;

    logic en;

    // The pipeline advances unless a finished beat is waiting on the receiver.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic                 pv;
    logic signed [AW-1:0] pa, pb, pc;
    logic [T-1:0]         pf;

    sscol_prep #(.W(W), .T(T)) u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata[IB-1:0]),
        .out_valid(pv),
        .a_out    (pa),
        .b_out    (pb),
        .c_out    (pc),
        .f_out    (pf)
    );

    logic                 v_w  [T+1];
    logic signed [AW-1:0] a_w  [T+1];
    logic signed [GW-1:0] h_w  [T+1];
    logic signed [GW-1:0] g_w  [T+1];
    logic [T-1:0]         k_w  [T+1];
    status_t              st_w [T+1];
    logic [T-1:0]         f_w  [T+1];

    sscol_disc #(.W(W), .T(T)) u_disc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pv),
        .a_in      (pa),
        .b_in      (pb),
        .c_in      (pc),
        .f_in      (pf),
        .out_valid (v_w[0]),
        .a_out     (a_w[0]),
        .h0_out    (h_w[0]),
        .g0_out    (g_w[0]),
        .status_out(st_w[0]),
        .f_out     (f_w[0])
    );

    assign k_w[0] = '0;

    // Binary search of the contact time, most significant bit first.
    for (genvar i = 0; i < T; i++) begin : g_search
        sscol_bisect #(.W(W), .T(T), .BIT(T-1-i)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_w[i]),
            .a_in      (a_w[i]),
            .h_in      (h_w[i]),
            .g_in      (g_w[i]),
            .k_in      (k_w[i]),
            .status_in (st_w[i]),
            .f_in      (f_w[i]),
            .out_valid (v_w[i+1]),
            .a_out     (a_w[i+1]),
            .h_out     (h_w[i+1]),
            .g_out     (g_w[i+1]),
            .k_out     (k_w[i+1]),
            .status_out(st_w[i+1]),
            .f_out     (f_w[i+1])
        );
    end

    // Output register: hit flag and time picked by status.
    logic          m_tvalid_reg;
    logic [OB-1:0] m_tdata_reg, m_tdata_next;
    status_t       st_final;
    logic          hit_w;
    logic [T-1:0]  time_w;

    always_comb begin
        st_final = st_w[T];
        hit_w    = 1'b0;
        time_w   = '0;
        case (st_final)
            ST_OVERLAP: begin
                hit_w  = 1'b1;
                time_w = f_w[T];
            end
            ST_CONTACT: begin
                hit_w  = 1'b1;
                time_w = k_w[T];
            end
            default: begin
                hit_w  = 1'b0;
                time_w = '0;
            end
        endcase
        m_tdata_next = OB'({st_final, time_w, hit_w});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v_w[T];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A hit is reported exactly for overlap and in-frame contact.
    a_hit_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == ((m_tdata[T+3:T+1] == ST_OVERLAP) ||
                                     (m_tdata[T+3:T+1] == ST_CONTACT))))
        else $error("hit flag disagrees with status");

    // The contact time is zero when there is no hit.
    a_time_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[T:1] == '0))
        else $error("nonzero time without hit");

    // A stalled output beat blocks the input side.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // A stalled output beat is still there in the next cycle with the same data.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output beat changed");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for swept_sphere_collision_time_top.
// Depends on sscol_pkg and the RTL of the block. Sphere pairs go in on the stream
// input, and an exact wide-integer predictor checks each contact result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sscol_pkg::*;

    localparam int CW       = 32;
    localparam int TB       = 16;
    localparam int IN_W     = ((7*CW-1+TB+7)/8)*8;
    localparam int OUT_W    = ((TB+4+7)/8)*8;
    localparam int N_RANDOM = 1350;
    localparam int LIMIT    = 400000;

    typedef logic signed [255:0] wide_t;

    // Result beat layout from the top bit down: status, collision_time, hit.
    typedef struct packed {
        status_t     status;
        logic [15:0] ctime;
        logic        hit;
    } contact_t;

    typedef struct {
        logic signed [31:0] s [3];
        logic signed [31:0] e [3];
        logic [30:0]        radius;
        logic [15:0]        phi;
    } pair_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    int send_idle_pct;
    int recv_stall_pct;
    int cycles;

    swept_sphere_collision_time_top #(.COORD_WIDTH(CW), .TIME_BITS(TB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Exact test: is the first root at or after k / 2^TB?
    function automatic bit first_root_not_before(wide_t a, wide_t b, wide_t c, wide_t k);
        wide_t p, slope, val;
        p = wide_t'(1) <<< TB;
        slope = a * k + b * p;
        val = a * k * k + 2 * b * k * p + c * p * p;
        return (slope <= 0) && (val >= 0);
    endfunction

    // Contact time and status of one sphere pair.
    function automatic contact_t solve_contact(logic [IN_W-1:0] beat);
        wide_t a, b, c, sv, dv, fw, pw, disc, h, cf, b1, c1, k, cand;
        logic signed [31:0] sc, ec;
        contact_t res;
        a = 0;
        b = 0;
        c = -(wide_t'(beat[222:192]) * wide_t'(beat[222:192]));
        for (int i = 0; i < 3; i++) begin
            sc = beat[32*i +: 32];
            ec = beat[32*(i+3) +: 32];
            sv = wide_t'(sc);
            dv = wide_t'(ec) - sv;
            a = a + dv * dv;
            b = b + sv * dv;
            c = c + sv * sv;
        end
        fw = wide_t'(beat[238:223]);
        pw = wide_t'(1) <<< TB;
        disc = b * b - a * c;
        h = a * fw + b * pw;
        cf = a * fw * fw + 2 * b * fw * pw + c * pw * pw;
        res.hit = 1'b0;
        res.ctime = '0;
        if (a == 0) begin
            res.status = ST_STILL;
        end else if (disc < 0) begin
            res.status = ST_MISS;
        end else if (h > 0 && cf > 0) begin
            res.status = ST_SEPARATING;
        end else if (cf < 0 || (cf == 0 && h > 0)) begin
            res.status = ST_OVERLAP;
            res.hit = 1'b1;
            res.ctime = beat[238:223];
        end else begin
            b1 = a + b;
            c1 = a + 2 * b + c;
            if (b1 > 0 || c1 < 0) begin
                // Binary search of the truncated contact time.
                k = 0;
                for (int bit_i = TB - 1; bit_i >= 0; bit_i--) begin
                    cand = k | (wide_t'(1) <<< bit_i);
                    if (first_root_not_before(a, b, c, cand))
                        k = cand;
                end
                res.status = ST_CONTACT;
                res.hit = 1'b1;
                res.ctime = k[15:0];
            end else begin
                res.status = ST_LATE;
            end
        end
        return res;
    endfunction

    // Holds the contact results still owed by the block, oldest first.
    class contact_scoreboard;
        contact_t owed[$];
        int       errors = 0;

        task report(string msg);
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
            errors++;
        endtask

        function void note_pair(logic [IN_W-1:0] beat);
            owed = {owed, solve_contact(beat)};
        endfunction

        task check_result(logic [OUT_W-1:0] beat);
            contact_t want;
            contact_t got;
            got = beat[19:0];
            if (beat[OUT_W-1:20] != '0)
                report($sformatf("fill bits not zero: %h", beat));
            if (owed.size() == 0) begin
                report("result beat with no pair waiting");
            end else begin
                want = owed.pop_front();
                if (got.hit !== want.hit)
                    report($sformatf("hit %b, expected %b", got.hit, want.hit));
                if (got.ctime !== want.ctime)
                    report($sformatf("collision_time %h, expected %h",
                                     got.ctime, want.ctime));
                if (got.status !== want.status)
                    report($sformatf("status %0d, expected %0d",
                                     got.status, want.status));
            end
        endtask
    endclass

    contact_scoreboard sb = new();

    function automatic logic [IN_W-1:0] pack_pair(pair_t p);
        logic [IN_W-1:0] beat;
        beat = '0;
        for (int i = 0; i < 3; i++) begin
            beat[32*i +: 32] = p.s[i];
            beat[32*(i+3) +: 32] = p.e[i];
        end
        beat[222:192] = p.radius;
        beat[238:223] = p.phi;
        return beat;
    endfunction

    // Send one beat, then sometimes idle, as set by send_idle_pct.
    task automatic send_pair(pair_t p);
        s_tvalid <= 1'b1;
        s_tdata <= pack_pair(p);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_pair(pack_pair(p));
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    function automatic pair_t make_pair(int sx, int sy, int sz, int ex, int ey, int ez,
                                        logic [30:0] r, logic [15:0] phi);
        pair_t p;
        p.s[0] = sx; p.s[1] = sy; p.s[2] = sz;
        p.e[0] = ex; p.e[1] = ey; p.e[2] = ez;
        p.radius = r;
        p.phi = phi;
        return p;
    endfunction

    // Mostly paths aimed near each other at a random scale, some raw noise.
    function automatic pair_t random_pair();
        pair_t p;
        int sh, kind;
        sh = $urandom_range(30, 2);
        kind = $urandom_range(99);
        for (int i = 0; i < 3; i++) begin
            if (kind < 25) begin
                p.s[i] = $urandom;
                p.e[i] = $urandom;
            end else begin
                p.s[i] = $signed($urandom_range((1 << sh) - 1)) - (1 <<< (sh - 1));
                p.e[i] = -p.s[i] + ($signed($urandom_range((1 << (sh - 1)) - 1))
                                    - (1 <<< (sh - 2)));
            end
        end
        if (kind >= 95)
            p.e = p.s;
        else if (kind >= 90) begin
            p.e = p.s;
            p.e[$urandom_range(2)] ^= 32'(1 << $urandom_range(31));
        end
        p.radius = (kind < 25 || kind >= 85) ? 31'($urandom) : 31'($urandom_range((1 << sh) - 1));
        case ($urandom_range(3))
            0:       p.phi = '0;
            default: p.phi = 16'($urandom);
        endcase
        return p;
    endfunction

    // Result channel ready pattern.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every accepted result beat.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        localparam int U = 65536;
        pair_t p;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pairs: each status, the tangent case and field extremes.
        send_pair(make_pair(U, 0, 0, U, 0, 0, 31'(2*U), 16'd0));        // still, overlapping
        send_pair(make_pair(5*U, 0, 0, 5*U, 0, 0, 31'(U), 16'hffff));   // still, apart
        send_pair(make_pair(-4*U, 3*U, 0, 4*U, 3*U, 0, 31'(U), 16'd0));  // miss
        send_pair(make_pair(2*U, 0, 0, 5*U, 0, 0, 31'(U), 16'd0));       // separating
        send_pair(make_pair(0, 0, U, U, 0, U, 31'(2*U), 16'd100));       // overlapping
        send_pair(make_pair(-4*U, 0, 0, 4*U, 0, 0, 31'(U), 16'd0));      // contact
        send_pair(make_pair(0, -4*U, 0, 0, 4*U, 0, 31'(U), 16'hffff));   // separating at late phi
        send_pair(make_pair(0, 0, -9*U, 0, 0, -3*U, 31'(U), 16'd0));     // after frame
        send_pair(make_pair(-2*U, U, 0, 2*U, U, 0, 31'(U), 16'h8000));   // tangent at phi
        send_pair(make_pair(-2*U, U, 0, 2*U, U, 0, 31'(U), 16'd0));      // tangent in frame
        send_pair(make_pair(-2*U, U, 0, 2*U, U, 0, 31'(U), 16'h8001));   // tangent passed
        send_pair(make_pair(-4*U, 0, 0, 4*U, 0, 0, 31'(U), 16'h4000));   // contact after phi
        send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            31'h7fffffff, 16'hffff));
        send_pair(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h80000000, 32'h80000000, 32'h80000000,
                            31'h7fffffff, 16'd0));
        send_pair(make_pair(32'h7fffffff, 32'h80000000, 0,
                            32'h80000000, 32'h7fffffff, 0, 31'd0, 16'h0001));
        send_pair(make_pair(-1, -1, -1, 0, 0, 0, 31'd0, 16'd0));
        send_pair(make_pair(32'h80000000, 0, 0, 32'h80000000, 0, 1, 31'h7fffffff, 16'h5555));
        send_pair(make_pair(-U, 0, 0, U, 0, 0, 31'd0, 16'd0));           // point contact at half
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 31'd0, 16'hffff));

        // Random pairs over the idling phases.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                p = random_pair();
                send_pair(p);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
